@@ rtl/deadline_timer_table_unit_macros.svh @@
// Assertion macros for the deadline timer table unit.
// Depends on nothing; each macro expects clk and rst_n in the enclosing scope.
`ifndef DEADLINE_TIMER_TABLE_UNIT_MACROS_SVH
`define DEADLINE_TIMER_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DTT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deadline timer table check failed");

// Next-cycle implication, disabled during reset.
`define DTT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deadline timer table check failed");

`endif

@@ rtl/dtt_pkg.sv @@
// Package for the deadline timer table unit: codes, sequencer types, constants.
// Depends on nothing.
package dtt_pkg;

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_CANCEL  = 3'd1;
    localparam logic [2:0] OP_REFRESH = 3'd2;
    localparam logic [2:0] OP_RESET   = 3'd3;
    localparam logic [2:0] OP_COLLECT = 3'd4;
    localparam logic [2:0] OP_QUERY   = 3'd5;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_INACTIVE = 3'd1;
    localparam logic [2:0] STS_FULL     = 3'd2;
    localparam logic [2:0] STS_EXPIRED  = 3'd3;
    localparam logic [2:0] STS_NONE     = 3'd4;

    localparam logic [31:0] WINDOW_RESET = 32'd3600000;
    localparam logic [63:0] WAIT_EMPTY   = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLOT,
        ST_RADD,
        ST_COLL,
        ST_SCAN,
        ST_QWAIT,
        ST_EMIT,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        SM_FRONT,
        SM_HIT,
        SM_MIN_VALID,
        SM_MIN_HIT
    } scan_mode_t;

endpackage

@@ rtl/deadline_timer_table_unit.sv @@
// Deadline timer table: slot storage, one shared deadline comparator and its sequencer.
// Depends on dtt_pkg and deadline_timer_table_unit_macros.svh.
//
//   channel  | direction | signals
//   in       | input     | in_valid, in_ready, op, now_ms, timer_id, period_ms,
//            |           | recurring, start_now, callback_tag
//   out      | output    | out_valid, out_ready, status, timer_id_res, callback_tag_res,
//            |           | wait_ms, front_wake, last
//   cfg      | input     | cfg_valid, cfg_ready, cfg_data
//
// Add, query and reset may run a scan; cancel and refresh never do.
// A scan reads one slot per cycle through the slot memory read port.
// Collect runs one scan to mark expired slots and one scan per expired timer.
// Reset clears the valid bits, wake flag and previous time at once; no clearing pass.
// Output stalls hold the sequencer at the result stage; in_ready is high only when idle.
`include "deadline_timer_table_unit_macros.svh"

module deadline_timer_table_unit #(
    parameter int NUM_TIMERS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [63:0] now_ms,
    input  logic [3:0]  timer_id,
    input  logic [31:0] period_ms,
    input  logic        recurring,
    input  logic        start_now,
    input  logic [15:0] callback_tag,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [3:0]  timer_id_res,
    output logic [15:0] callback_tag_res,
    output logic [63:0] wait_ms,
    output logic        front_wake,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam logic [CW-1:0] CNT_END = CW'(NUM_TIMERS);

    logic [63:0] mem_dl  [NUM_TIMERS];
    logic [31:0] mem_per [NUM_TIMERS];
    logic        mem_rec [NUM_TIMERS];
    logic [15:0] mem_tag [NUM_TIMERS];

    dtt_pkg::state_t     state_reg, state_next;
    dtt_pkg::scan_mode_t mode_reg, mode_next;

    logic [NUM_TIMERS-1:0] valid_reg, valid_next;
    logic [NUM_TIMERS-1:0] hit_reg, hit_next;
    logic        wake_reg, wake_next;
    logic [63:0] prev_reg, prev_next;
    logic [31:0] window_reg;
    logic        roll_reg, roll_next;

    logic [2:0]    op_reg, op_next;
    logic [63:0]   now_reg, now_next;
    logic [3:0]    id_reg, id_next;
    logic [31:0]   per_reg, per_next;
    logic          fnow_reg, fnow_next;
    logic [63:0]   start_reg, start_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pv_reg, pv_next;
    logic [IW-1:0] pi_reg, pi_next;
    logic [63:0]   rd_dl_reg;
    logic [31:0]   rd_per_reg;
    logic          rd_rec_reg;
    logic [15:0]   rd_tag_reg;
    logic [IW-1:0] rd_addr;

    logic [IW-1:0] s_idx_reg, s_idx_next;
    logic [63:0]   s_dl_reg, s_dl_next;
    logic          found_reg, found_next;
    logic [IW-1:0] b_idx_reg, b_idx_next;
    logic [63:0]   b_dl_reg, b_dl_next;
    logic [31:0]   b_per_reg, b_per_next;
    logic          b_rec_reg, b_rec_next;
    logic [15:0]   b_tag_reg, b_tag_next;

    logic [2:0]  res_sts_reg, res_sts_next;
    logic [3:0]  res_id_reg, res_id_next;
    logic [15:0] res_tag_reg, res_tag_next;
    logic [63:0] res_wait_reg, res_wait_next;
    logic        res_front_reg, res_front_next;
    logic        res_last_reg, res_last_next;

    logic        ov_reg, ov_next;
    logic [2:0]  o_sts_reg, o_sts_next;
    logic [3:0]  o_id_reg, o_id_next;
    logic [15:0] o_tag_reg, o_tag_next;
    logic [63:0] o_wait_reg, o_wait_next;
    logic        o_front_reg, o_front_next;
    logic        o_last_reg, o_last_next;

    logic          we_dl, we_per, we_rt;
    logic [IW-1:0] wa;
    logic [63:0]   w_dl;
    logic [31:0]   w_per;
    logic          w_rec;
    logic [15:0]   w_tag;

    logic          accept, out_free, in_range, scan_done;
    logic          free_found;
    logic [IW-1:0] free_idx;
    logic [63:0]   ref_dl;
    logic          cmp_lt, cmp_eq, cand;
    logic [NUM_TIMERS-1:0] best_bit;

    assign accept    = in_valid && in_ready;
    assign out_free  = !ov_reg || out_ready;
    assign in_range  = 32'(timer_id) < NUM_TIMERS;
    assign scan_done = (cnt_reg == CNT_END) && !pv_reg;
    assign in_ready  = state_reg == dtt_pkg::ST_IDLE;
    assign cfg_ready = 1'b1;

    assign out_valid        = ov_reg;
    assign status           = o_sts_reg;
    assign timer_id_res     = o_id_reg;
    assign callback_tag_res = o_tag_reg;
    assign wait_ms          = o_wait_reg;
    assign front_wake       = o_front_reg;
    assign last             = o_last_reg;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    always_comb
    begin
        unique case (mode_reg)
            dtt_pkg::SM_FRONT: ref_dl = s_dl_reg;
            dtt_pkg::SM_HIT:   ref_dl = now_reg;
            default:           ref_dl = b_dl_reg;
        endcase
    end

    assign cmp_lt   = rd_dl_reg < ref_dl;
    assign cmp_eq   = rd_dl_reg == ref_dl;
    assign best_bit = NUM_TIMERS'(1) << b_idx_reg;

    always_comb
    begin
        unique case (mode_reg)
            dtt_pkg::SM_FRONT:
                cand = pv_reg && (pi_reg != s_idx_reg) && valid_reg[pi_reg]
                       && (cmp_lt || (cmp_eq && (pi_reg < s_idx_reg)));
            dtt_pkg::SM_HIT:
                cand = pv_reg && valid_reg[pi_reg] && (roll_reg || cmp_lt || cmp_eq);
            dtt_pkg::SM_MIN_VALID:
                cand = pv_reg && valid_reg[pi_reg] && (!found_reg || cmp_lt);
            default:
                cand = pv_reg && hit_reg[pi_reg] && (!found_reg || cmp_lt);
        endcase
    end

    always_comb
    begin
        if (state_reg == dtt_pkg::ST_SCAN)
            rd_addr = cnt_reg[IW-1:0];
        else
            rd_addr = IW'(timer_id);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dtt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        dtt_pkg::OP_ADD:
                            state_next = free_found ? dtt_pkg::ST_SCAN : dtt_pkg::ST_RESP;
                        dtt_pkg::OP_CANCEL, dtt_pkg::OP_REFRESH, dtt_pkg::OP_RESET:
                            state_next = in_range ? dtt_pkg::ST_SLOT : dtt_pkg::ST_RESP;
                        dtt_pkg::OP_COLLECT:
                            state_next = (|valid_reg) ? dtt_pkg::ST_COLL : dtt_pkg::ST_RESP;
                        dtt_pkg::OP_QUERY:
                            state_next = dtt_pkg::ST_SCAN;
                        default:
                            state_next = dtt_pkg::ST_IDLE;
                    endcase
                end
            end
            dtt_pkg::ST_SLOT:
            begin
                if (op_reg == dtt_pkg::OP_RESET && !(per_reg == rd_per_reg && !fnow_reg)
                    && valid_reg[id_reg[IW-1:0]])
                    state_next = dtt_pkg::ST_RADD;
                else
                    state_next = dtt_pkg::ST_RESP;
            end
            dtt_pkg::ST_RADD:  state_next = dtt_pkg::ST_SCAN;
            dtt_pkg::ST_COLL:  state_next = dtt_pkg::ST_SCAN;
            dtt_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    unique case (mode_reg)
                        dtt_pkg::SM_FRONT:     state_next = dtt_pkg::ST_RESP;
                        dtt_pkg::SM_HIT:
                            state_next = (|hit_reg) ? dtt_pkg::ST_SCAN : dtt_pkg::ST_RESP;
                        dtt_pkg::SM_MIN_VALID: state_next = dtt_pkg::ST_QWAIT;
                        default:               state_next = dtt_pkg::ST_EMIT;
                    endcase
                end
            end
            dtt_pkg::ST_QWAIT: state_next = dtt_pkg::ST_RESP;
            dtt_pkg::ST_EMIT:  state_next = dtt_pkg::ST_RESP;
            dtt_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    if (op_reg == dtt_pkg::OP_COLLECT && !res_last_reg)
                        state_next = dtt_pkg::ST_SCAN;
                    else
                        state_next = dtt_pkg::ST_IDLE;
                end
            end
            default: state_next = dtt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        mode_next  = mode_reg;
        valid_next = valid_reg;
        hit_next   = hit_reg;
        wake_next  = wake_reg;
        prev_next  = prev_reg;
        roll_next  = roll_reg;
        op_next    = op_reg;
        now_next   = now_reg;
        id_next    = id_reg;
        per_next   = per_reg;
        fnow_next  = fnow_reg;
        start_next = start_reg;
        cnt_next   = cnt_reg;
        pv_next    = 1'b0;
        pi_next    = pi_reg;
        s_idx_next = s_idx_reg;
        s_dl_next  = s_dl_reg;
        found_next = found_reg;
        b_idx_next = b_idx_reg;
        b_dl_next  = b_dl_reg;
        b_per_next = b_per_reg;
        b_rec_next = b_rec_reg;
        b_tag_next = b_tag_reg;
        res_sts_next   = res_sts_reg;
        res_id_next    = res_id_reg;
        res_tag_next   = res_tag_reg;
        res_wait_next  = res_wait_reg;
        res_front_next = res_front_reg;
        res_last_next  = res_last_reg;
        ov_next      = ov_reg && !out_ready;
        o_sts_next   = o_sts_reg;
        o_id_next    = o_id_reg;
        o_tag_next   = o_tag_reg;
        o_wait_next  = o_wait_reg;
        o_front_next = o_front_reg;
        o_last_next  = o_last_reg;
        we_dl  = 1'b0;
        we_per = 1'b0;
        we_rt  = 1'b0;
        wa     = s_idx_reg;
        w_dl   = '0;
        w_per  = per_reg;
        w_rec  = recurring;
        w_tag  = callback_tag;

        unique case (state_reg)
            dtt_pkg::ST_IDLE:
            begin
                res_sts_next   = dtt_pkg::STS_OK;
                res_id_next    = timer_id;
                res_tag_next   = '0;
                res_wait_next  = '0;
                res_front_next = 1'b0;
                res_last_next  = 1'b1;
                cnt_next       = '0;
                found_next     = 1'b0;
                if (accept)
                begin
                    op_next   = op;
                    now_next  = now_ms;
                    id_next   = timer_id;
                    per_next  = period_ms;
                    fnow_next = start_now;
                    unique case (op)
                        dtt_pkg::OP_ADD:
                        begin
                            if (free_found)
                            begin
                                we_dl  = 1'b1;
                                we_per = 1'b1;
                                we_rt  = 1'b1;
                                wa     = free_idx;
                                w_dl   = now_ms + 64'(period_ms);
                                w_per  = period_ms;
                                valid_next[free_idx] = 1'b1;
                                s_idx_next  = free_idx;
                                s_dl_next   = w_dl;
                                mode_next   = dtt_pkg::SM_FRONT;
                                res_id_next = 4'(free_idx);
                            end
                            else
                            begin
                                res_sts_next = dtt_pkg::STS_FULL;
                                res_id_next  = '0;
                            end
                        end
                        dtt_pkg::OP_CANCEL, dtt_pkg::OP_REFRESH, dtt_pkg::OP_RESET:
                        begin
                            if (!in_range)
                                res_sts_next = dtt_pkg::STS_INACTIVE;
                        end
                        dtt_pkg::OP_COLLECT:
                        begin
                            res_sts_next = dtt_pkg::STS_NONE;
                            res_id_next  = '0;
                        end
                        dtt_pkg::OP_QUERY:
                        begin
                            wake_next   = 1'b0;
                            mode_next   = dtt_pkg::SM_MIN_VALID;
                            res_id_next = '0;
                        end
                        default:
                        begin
                            res_last_next = 1'b1;
                        end
                    endcase
                end
            end
            dtt_pkg::ST_SLOT:
            begin
                wa = id_reg[IW-1:0];
                s_idx_next = id_reg[IW-1:0];
                unique case (op_reg)
                    dtt_pkg::OP_CANCEL:
                    begin
                        if (!valid_reg[id_reg[IW-1:0]])
                            res_sts_next = dtt_pkg::STS_INACTIVE;
                        else
                            valid_next[id_reg[IW-1:0]] = 1'b0;
                    end
                    dtt_pkg::OP_REFRESH:
                    begin
                        if (!valid_reg[id_reg[IW-1:0]])
                            res_sts_next = dtt_pkg::STS_INACTIVE;
                        else
                        begin
                            we_dl = 1'b1;
                            w_dl  = now_reg + 64'(rd_per_reg);
                        end
                    end
                    default:
                    begin
                        if (per_reg == rd_per_reg && !fnow_reg)
                            res_sts_next = dtt_pkg::STS_OK;
                        else if (!valid_reg[id_reg[IW-1:0]])
                            res_sts_next = dtt_pkg::STS_INACTIVE;
                        else
                            start_next = fnow_reg ? now_reg : rd_dl_reg - 64'(rd_per_reg);
                    end
                endcase
            end
            dtt_pkg::ST_RADD:
            begin
                we_dl     = 1'b1;
                we_per    = 1'b1;
                w_dl      = start_reg + 64'(per_reg);
                s_dl_next = w_dl;
                mode_next = dtt_pkg::SM_FRONT;
            end
            dtt_pkg::ST_COLL:
            begin
                roll_next = (now_reg < prev_reg)
                            && ((prev_reg - now_reg) > 64'(window_reg));
                prev_next = now_reg;
                hit_next  = '0;
                mode_next = dtt_pkg::SM_HIT;
            end
            dtt_pkg::ST_SCAN:
            begin
                if (cnt_reg != CNT_END)
                begin
                    pv_next  = 1'b1;
                    pi_next  = cnt_reg[IW-1:0];
                    cnt_next = cnt_reg + CW'(1);
                end
                if (cand)
                begin
                    unique case (mode_reg)
                        dtt_pkg::SM_FRONT: found_next = 1'b1;
                        dtt_pkg::SM_HIT:   hit_next[pi_reg] = 1'b1;
                        default:
                        begin
                            found_next = 1'b1;
                            b_idx_next = pi_reg;
                            b_dl_next  = rd_dl_reg;
                            b_per_next = rd_per_reg;
                            b_rec_next = rd_rec_reg;
                            b_tag_next = rd_tag_reg;
                        end
                    endcase
                end
                if (scan_done)
                begin
                    cnt_next   = '0;
                    found_next = 1'b0;
                    unique case (mode_reg)
                        dtt_pkg::SM_FRONT:
                        begin
                            res_front_next = !found_reg && !wake_reg;
                            if (!found_reg)
                                wake_next = 1'b1;
                        end
                        dtt_pkg::SM_HIT:
                            mode_next = dtt_pkg::SM_MIN_HIT;
                        default:
                            found_next = found_reg;
                    endcase
                end
            end
            dtt_pkg::ST_QWAIT:
            begin
                if (!found_reg)
                    res_wait_next = dtt_pkg::WAIT_EMPTY;
                else if (now_reg >= b_dl_reg)
                    res_wait_next = '0;
                else
                    res_wait_next = b_dl_reg - now_reg;
            end
            dtt_pkg::ST_EMIT:
            begin
                res_sts_next  = dtt_pkg::STS_EXPIRED;
                res_id_next   = 4'(b_idx_reg);
                res_tag_next  = b_tag_reg;
                res_last_next = (hit_reg & ~best_bit) == '0;
                hit_next      = hit_reg & ~best_bit;
                wa            = b_idx_reg;
                if (b_rec_reg)
                begin
                    we_dl = 1'b1;
                    w_dl  = now_reg + 64'(b_per_reg);
                end
                else
                    valid_next[b_idx_reg] = 1'b0;
            end
            dtt_pkg::ST_RESP:
            begin
                cnt_next   = '0;
                found_next = 1'b0;
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    o_sts_next   = res_sts_reg;
                    o_id_next    = res_id_reg;
                    o_tag_next   = res_tag_reg;
                    o_wait_next  = res_wait_reg;
                    o_front_next = res_front_reg;
                    o_last_next  = res_last_reg;
                end
            end
            default:
            begin
                pv_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we_dl)
            mem_dl[wa] <= w_dl;
        if (we_per)
            mem_per[wa] <= w_per;
        if (we_rt)
        begin
            mem_rec[wa] <= w_rec;
            mem_tag[wa] <= w_tag;
        end
        rd_dl_reg  <= mem_dl[rd_addr];
        rd_per_reg <= mem_per[rd_addr];
        rd_rec_reg <= mem_rec[rd_addr];
        rd_tag_reg <= mem_tag[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dtt_pkg::ST_IDLE;
            mode_reg   <= dtt_pkg::SM_FRONT;
            valid_reg  <= '0;
            hit_reg    <= '0;
            wake_reg   <= 1'b0;
            prev_reg   <= '0;
            window_reg <= dtt_pkg::WINDOW_RESET;
            cnt_reg    <= '0;
            pv_reg     <= 1'b0;
            found_reg  <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
            wake_reg  <= wake_next;
            prev_reg  <= prev_next;
            if (cfg_valid && cfg_ready)
                window_reg <= cfg_data;
            cnt_reg   <= cnt_next;
            pv_reg    <= pv_next;
            found_reg <= found_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        roll_reg       <= roll_next;
        op_reg         <= op_next;
        now_reg        <= now_next;
        id_reg         <= id_next;
        per_reg        <= per_next;
        fnow_reg       <= fnow_next;
        start_reg      <= start_next;
        pi_reg         <= pi_next;
        s_idx_reg      <= s_idx_next;
        s_dl_reg       <= s_dl_next;
        b_idx_reg      <= b_idx_next;
        b_dl_reg       <= b_dl_next;
        b_per_reg      <= b_per_next;
        b_rec_reg      <= b_rec_next;
        b_tag_reg      <= b_tag_next;
        res_sts_reg    <= res_sts_next;
        res_id_reg     <= res_id_next;
        res_tag_reg    <= res_tag_next;
        res_wait_reg   <= res_wait_next;
        res_front_reg  <= res_front_next;
        res_last_reg   <= res_last_next;
        o_sts_reg      <= o_sts_next;
        o_id_reg       <= o_id_next;
        o_tag_reg      <= o_tag_next;
        o_wait_reg     <= o_wait_next;
        o_front_reg    <= o_front_next;
        o_last_reg     <= o_last_next;
    end

    `DTT_ASSERT_NEXT(a_scan_drains, (state_reg == dtt_pkg::ST_SCAN) && (cnt_reg == CNT_END), !pv_reg)
    `DTT_ASSERT_NOW(a_emit_has_best, state_reg == dtt_pkg::ST_EMIT, found_reg)
    `DTT_ASSERT_NOW(a_last_expired_clears, (state_reg == dtt_pkg::ST_RESP) && out_free && (res_sts_reg == dtt_pkg::STS_EXPIRED) && res_last_reg, hit_reg == '0)
    `DTT_ASSERT_NEXT(a_front_sets_wake, (state_reg == dtt_pkg::ST_RESP) && out_free && res_front_reg, wake_reg)

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the deadline timer table unit: directed rows, then random traffic.
// Depends on dtt_pkg and the deadline_timer_table_unit RTL; it predicts every result itself.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [2:0]  op;
        logic [63:0] now;
        logic [3:0]  id;
        logic [31:0] period;
        logic        rec;
        logic        fnow;
        logic [15:0] tag;
        bit          typed;
        logic [2:0]  exp_st;
        logic [63:0] exp_wt;
    } request_t;

    typedef struct {
        logic [2:0]  st;
        logic [3:0]  id;
        logic [15:0] tag;
        logic [63:0] wt;
        logic        front;
        logic        fin;
    } timer_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  op = '0;
    logic [63:0] now_ms = '0;
    logic [3:0]  timer_id = '0;
    logic [31:0] period_ms = '0;
    logic        recurring = 1'b0;
    logic        start_now = 1'b0;
    logic [15:0] callback_tag = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [3:0]  timer_id_res;
    logic [15:0] callback_tag_res;
    logic [63:0] wait_ms;
    logic        front_wake;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    bit          armed_valid [SLOTS];
    bit          ever_armed [SLOTS];
    logic [63:0] armed_deadline [SLOTS];
    logic [31:0] armed_period [SLOTS];
    bit          armed_recurring [SLOTS];
    logic [15:0] armed_tag [SLOTS];
    bit          wake_flag;
    logic [63:0] last_collect_time;
    logic [31:0] window_ms;

    timer_result_t pending_results[$];
    int  fail_count = 0;
    bit  calm = 1'b0;

    deadline_timer_table_unit #(.NUM_TIMERS(SLOTS)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .now_ms(now_ms),
        .timer_id(timer_id), .period_ms(period_ms), .recurring(recurring),
        .start_now(start_now), .callback_tag(callback_tag),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .timer_id_res(timer_id_res), .callback_tag_res(callback_tag_res),
        .wait_ms(wait_ms), .front_wake(front_wake), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("[deadline_timer_table_unit] ERROR");
        $finish;
    end

    function automatic bit ahead_of(int a, int b);
        if (armed_deadline[a] != armed_deadline[b])
            return armed_deadline[a] < armed_deadline[b];
        return a < b;
    endfunction

    function automatic void push_result(logic [2:0] st, logic [3:0] id, logic [15:0] tag,
                                        logic [63:0] wt, logic front, logic fin);
        timer_result_t r;
        r.st = st; r.id = id; r.tag = tag; r.wt = wt; r.front = front; r.fin = fin;
        pending_results = {pending_results, r};
    endfunction

    function automatic logic wake_on_front(int s);
        for (int i = 0; i < SLOTS; i++)
            if (i != s && armed_valid[i] && ahead_of(i, s))
                return 1'b0;
        if (wake_flag)
            return 1'b0;
        wake_flag = 1'b1;
        return 1'b1;
    endfunction

    function automatic void predict_timer_request(request_t q);
        int free_slot;
        int best;
        int hits;
        bit any;
        bit roll;
        bit hit [SLOTS];
        logic [63:0] start;
        logic [63:0] wt;
        free_slot = -1;
        best = -1;
        hits = 0;
        any = 1'b0;
        case (q.op)
            dtt_pkg::OP_ADD:
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!armed_valid[i])
                        free_slot = i;
                if (free_slot < 0)
                    push_result(dtt_pkg::STS_FULL, 0, 0, 0, 0, 1);
                else
                begin
                    armed_valid[free_slot] = 1;
                    ever_armed[free_slot] = 1;
                    armed_deadline[free_slot] = q.now + 64'(q.period);
                    armed_period[free_slot] = q.period;
                    armed_recurring[free_slot] = q.rec;
                    armed_tag[free_slot] = q.tag;
                    push_result(dtt_pkg::STS_OK, free_slot[3:0], 0, 0,
                                wake_on_front(free_slot), 1);
                end
            end
            dtt_pkg::OP_CANCEL, dtt_pkg::OP_REFRESH:
            begin
                if (!armed_valid[q.id])
                    push_result(dtt_pkg::STS_INACTIVE, q.id, 0, 0, 0, 1);
                else
                begin
                    if (q.op == dtt_pkg::OP_CANCEL)
                        armed_valid[q.id] = 0;
                    else
                        armed_deadline[q.id] = q.now + 64'(armed_period[q.id]);
                    push_result(dtt_pkg::STS_OK, q.id, 0, 0, 0, 1);
                end
            end
            dtt_pkg::OP_RESET:
            begin
                if (q.period == armed_period[q.id] && !q.fnow)
                    push_result(dtt_pkg::STS_OK, q.id, 0, 0, 0, 1);
                else if (!armed_valid[q.id])
                    push_result(dtt_pkg::STS_INACTIVE, q.id, 0, 0, 0, 1);
                else
                begin
                    start = q.fnow ? q.now : armed_deadline[q.id] - 64'(armed_period[q.id]);
                    armed_period[q.id] = q.period;
                    armed_deadline[q.id] = start + 64'(q.period);
                    push_result(dtt_pkg::STS_OK, q.id, 0, 0, wake_on_front(q.id), 1);
                end
            end
            dtt_pkg::OP_COLLECT:
            begin
                for (int i = 0; i < SLOTS; i++)
                    any |= armed_valid[i];
                if (!any)
                    push_result(dtt_pkg::STS_NONE, 0, 0, 0, 0, 1);
                else
                begin
                    roll = q.now < last_collect_time &&
                           (last_collect_time - q.now) > 64'(window_ms);
                    last_collect_time = q.now;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        hit[i] = armed_valid[i] && (roll || armed_deadline[i] <= q.now);
                        if (hit[i])
                            hits++;
                    end
                    if (hits == 0)
                        push_result(dtt_pkg::STS_NONE, 0, 0, 0, 0, 1);
                    for (int k = 0; k < hits; k++)
                    begin
                        best = -1;
                        for (int i = 0; i < SLOTS; i++)
                            if (hit[i] && (best < 0 || ahead_of(i, best)))
                                best = i;
                        hit[best] = 0;
                        push_result(dtt_pkg::STS_EXPIRED, best[3:0], armed_tag[best], 0, 0,
                                    k == hits - 1);
                        if (armed_recurring[best])
                            armed_deadline[best] = q.now + 64'(armed_period[best]);
                        else
                            armed_valid[best] = 0;
                    end
                end
            end
            dtt_pkg::OP_QUERY:
            begin
                wake_flag = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (armed_valid[i] && (best < 0 || ahead_of(i, best)))
                        best = i;
                if (best < 0)
                    wt = dtt_pkg::WAIT_EMPTY;
                else if (q.now >= armed_deadline[best])
                    wt = 0;
                else
                    wt = armed_deadline[best] - q.now;
                push_result(dtt_pkg::STS_OK, 0, 0, wt, 0, 1);
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_request(request_t q);
        if (!calm && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= q.op;
        now_ms <= q.now;
        timer_id <= q.id;
        period_ms <= q.period;
        recurring <= q.rec;
        start_now <= q.fnow;
        callback_tag <= q.tag;
        do @(posedge clk); while (!in_ready);
        predict_timer_request(q);
        if (q.typed && (pending_results[$].st !== q.exp_st ||
                        pending_results[$].wt !== q.exp_wt))
        begin
            $display("%0t typed row disagrees: expected st=%0d wait=%h, predicted st=%0d wait=%h",
                     $time, q.exp_st, q.exp_wt, pending_results[$].st, pending_results[$].wt);
            fail_count++;
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_window(logic [31:0] value);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        window_ms = value;
    endtask

    function automatic request_t make_row(logic [2:0] o, logic [63:0] t, logic [3:0] id,
                                          logic [31:0] p, logic rec, logic fn, logic [15:0] tag,
                                          bit typed = 0, logic [2:0] est = 0,
                                          logic [63:0] ewt = 0);
        request_t q;
        q.op = o; q.now = t; q.id = id; q.period = p; q.rec = rec; q.fnow = fn; q.tag = tag;
        q.typed = typed; q.exp_st = est; q.exp_wt = ewt;
        return q;
    endfunction

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 22);

    always @(posedge clk)
    begin
        timer_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual st=%0d id=%0d",
                         $time, status, timer_id_res);
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.st || timer_id_res !== e.id || callback_tag_res !== e.tag ||
                    wait_ms !== e.wt || front_wake !== e.front || last !== e.fin)
                begin
                    $display("%0t mismatch: expected st=%0d id=%0d tag=%h wait=%h front=%b last=%b",
                             $time, e.st, e.id, e.tag, e.wt, e.front, e.fin);
                    $display("%0t            actual st=%0d id=%0d tag=%h wait=%h front=%b last=%b",
                             $time, status, timer_id_res, callback_tag_res, wait_ms,
                             front_wake, last);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        request_t rows[$];
        request_t q;
        logic [31:0] windows[4];
        logic [63:0] clock_now;
        int pick;
        window_ms = dtt_pkg::WINDOW_RESET;
        wake_flag = 0;
        last_collect_time = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            armed_valid[i] = 0; ever_armed[i] = 0; armed_deadline[i] = 0;
            armed_period[i] = 0; armed_recurring[i] = 0; armed_tag[i] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = {rows, make_row(dtt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 1, dtt_pkg::STS_OK,
                               dtt_pkg::WAIT_EMPTY)};
        rows = {rows, make_row(dtt_pkg::OP_COLLECT, 0, 0, 0, 0, 0, 0, 1, dtt_pkg::STS_NONE, 0)};
        rows = {rows, make_row(dtt_pkg::OP_CANCEL, 5, 3, 0, 0, 0, 0, 1,
                               dtt_pkg::STS_INACTIVE, 0)};
        rows = {rows, make_row(dtt_pkg::OP_REFRESH, 5, 15, 0, 0, 0, 0, 1,
                               dtt_pkg::STS_INACTIVE, 0)};
        rows = {rows, make_row(dtt_pkg::OP_RESET, 5, 6, 9, 0, 1, 0, 1,
                               dtt_pkg::STS_INACTIVE, 0)};
        rows = {rows, make_row(dtt_pkg::OP_ADD, 100, 0, 50, 1, 0, 16'hFFFF)};
        rows = {rows, make_row(dtt_pkg::OP_ADD, 100, 0, 0, 0, 0, 16'h0000)};
        rows = {rows, make_row(dtt_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 0, 32'hFFFF_FFFF,
                               1, 1, 16'hA5C3)};
        rows = {rows, make_row(dtt_pkg::OP_QUERY, 100, 0, 0, 0, 0, 0, 1, dtt_pkg::STS_OK, 0)};
        rows = {rows, make_row(dtt_pkg::OP_RESET, 120, 0, 50, 0, 0, 0)};
        rows = {rows, make_row(dtt_pkg::OP_RESET, 120, 0, 10, 0, 1, 0)};
        rows = {rows, make_row(dtt_pkg::OP_RESET, 120, 1, 30, 0, 0, 0)};
        rows = {rows, make_row(dtt_pkg::OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0)};
        rows = {rows, make_row(dtt_pkg::OP_REFRESH, 200, 0, 0, 0, 0, 0)};
        rows = {rows, make_row(OP_SPARE_A, 210, 2, 7, 1, 1, 16'h1234)};
        rows = {rows, make_row(dtt_pkg::OP_COLLECT, 1000, 0, 0, 0, 0, 0)};
        rows = {rows, make_row(dtt_pkg::OP_COLLECT, 0, 0, 0, 0, 0, 0)};
        rows = {rows, make_row(dtt_pkg::OP_CANCEL, 300, 1, 0, 0, 0, 0)};
        rows = {rows, make_row(dtt_pkg::OP_ADD, 64'h0000_0001_0000_0000, 0, 5, 0, 0,
                               16'h5A5A)};
        rows = {rows, make_row(dtt_pkg::OP_COLLECT, 64'h0000_0001_0000_0000, 0, 0, 0, 0, 0)};
        rows = {rows, make_row(dtt_pkg::OP_COLLECT, 7, 0, 0, 0, 0, 0)};
        rows = {rows, make_row(OP_SPARE_B, 7, 0, 0, 0, 0, 0)};
        rows = {rows, make_row(dtt_pkg::OP_QUERY, 8, 0, 0, 0, 0, 0)};
        foreach (rows[i])
            send_request(rows[i]);

        windows[0] = 32'd0;
        windows[1] = 32'hFFFF_FFFF;
        windows[2] = $urandom_range(0, 5000);
        windows[3] = dtt_pkg::WINDOW_RESET;
        clock_now = 1000;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_window(windows[ph]);
            for (int n = 0; n < 27; n++)
            begin
                calm = (ph == 1 && n >= 5 && n < 25);
                if (ph == 2 && n == 17)
                    drain_results();
                pick = $urandom_range(99);
                if (pick < 70)
                    clock_now += $urandom_range(0, 120);
                else if (pick < 80)
                    clock_now -= {$urandom_range(0, 3), $urandom};
                else if (pick < 86)
                    clock_now = {$urandom, $urandom};
                pick = $urandom_range(99);
                q = make_row(pick < 32 ? dtt_pkg::OP_ADD : pick < 42 ? dtt_pkg::OP_CANCEL :
                             pick < 52 ? dtt_pkg::OP_REFRESH : pick < 66 ? dtt_pkg::OP_RESET :
                             pick < 84 ? dtt_pkg::OP_COLLECT : pick < 97 ? dtt_pkg::OP_QUERY :
                             3'($urandom_range(6, 7)),
                             clock_now, 4'($urandom), 32'($urandom_range(0, 200)),
                             1'($urandom), 1'($urandom), 16'($urandom));
                if ($urandom_range(9) == 0)
                    q.period = $urandom;
                if (q.op == dtt_pkg::OP_RESET && $urandom_range(1) == 0 && ever_armed[q.id])
                    q.period = armed_period[q.id];
                if (q.op == dtt_pkg::OP_RESET && !ever_armed[q.id])
                    q.fnow = 1'b1;
                send_request(q);
            end
            calm = 0;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[deadline_timer_table_unit] OK");
        else
            $display("[deadline_timer_table_unit] ERROR");
        $finish;
    end
endmodule
